>>> rtl/bsdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BLE service data parser package
// Shared types, element and item codes for the advertisement parser.
// ----------------------------------------------------------------------------
package bsdp_pkg;

   localparam logic [7:0]  AD_SERVICE_DATA  = 8'h16;
   localparam logic [7:0]  UUID_LO          = 8'hD2;
   localparam logic [7:0]  UUID_HI          = 8'hFC;
   localparam logic [7:0]  FLAG_ENCRYPTED   = 8'h01;
   localparam logic [7:0]  VERSION_MASK     = 8'hE0;
   localparam logic [7:0]  VERSION_2        = 8'h40;
   localparam logic [7:0]  ITEM_PACKET_ID   = 8'h00;
   localparam logic [7:0]  ITEM_BATTERY     = 8'h01;
   localparam logic [7:0]  ITEM_HUMIDITY    = 8'h2E;
   localparam logic [7:0]  ITEM_TEMPERATURE = 8'h45;
   localparam logic [7:0]  ITEM_BUTTON      = 8'h3A;
   localparam logic [7:0]  BUTTON_PRESS     = 8'h01;
   localparam logic [7:0]  MIN_SERVICE_LEFT = 8'd5;
   localparam logic [31:0] MAX_AGE_RESET    = 32'd600;

   typedef enum logic [3:0] {
      MODE_LEN       = 4'd0,
      MODE_TYPE      = 4'd1,
      MODE_SKIP      = 4'd2,
      MODE_UUID0     = 4'd3,
      MODE_UUID1     = 4'd4,
      MODE_FLAGS     = 4'd5,
      MODE_ITEM_TYPE = 4'd6,
      MODE_ITEM_DATA = 4'd7,
      MODE_DRAIN     = 4'd8
   } mode_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [7:0]  total_length;
      logic [31:0] current_time;
   } item_type;

   typedef struct packed {
      logic [7:0]         packet_id;
      logic [7:0]         battery_level;
      logic [7:0]         humidity;
      logic signed [15:0] temperature;
      logic               button_pressed;
      logic               parse_error;
      logic               data_valid;
   } result_type;

   // Bytes an item needs including its type byte; zero marks an unknown type.
   function automatic logic [1:0] item_size(input logic [7:0] t);
      logic [1:0] size;
      case (t) inside
         ITEM_PACKET_ID, ITEM_BATTERY, ITEM_HUMIDITY, ITEM_BUTTON: size = 2'd2;
         ITEM_TEMPERATURE:                                         size = 2'd3;
         default:                                                  size = 2'd0;
      endcase
      return size;
   endfunction

endpackage
`default_nettype wire

>>> rtl/bsdp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BLE service data parser step
// Holds the parse state and the decoded values; takes one byte per step and
// flags a result on the final byte of an advertisement.
// ----------------------------------------------------------------------------
module bsdp_parser
   import bsdp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step_valid,
   input  wire item_type    step_item,
   input  wire logic [31:0] max_data_age,
   output logic             result_valid,
   output result_type       result
);

   mode_type    mode_ff, mode_in;
   logic [7:0]  adv_left_ff, adv_left_in;
   logic [7:0]  el_left_ff, el_left_in;
   logic [7:0]  item_kind_ff, item_kind_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [7:0]  low_hold_ff, low_hold_in;
   logic [7:0]  packet_id_ff, packet_id_in;
   logic [7:0]  held_id_ff, held_id_in;
   logic [7:0]  prev_id_ff, prev_id_in;
   logic [7:0]  battery_ff, battery_in;
   logic [7:0]  humidity_ff, humidity_in;
   logic [15:0] temperature_ff, temperature_in;
   logic        button_ff, button_in;
   logic        error_ff, error_in;
   logic [31:0] last_ok_ff, last_ok_in;

   mode_type    mode_v, mode_c;
   logic [7:0]  adv_v, adv_n, el_v, el;
   logic        in_element, item_done, fresh;
   logic [1:0]  need;
   logic [31:0] age;
   logic [7:0]  b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_LEN;
         adv_left_ff    <= '0;
         el_left_ff     <= '0;
         item_kind_ff   <= '0;
         byte_index_ff  <= '0;
         low_hold_ff    <= '0;
         packet_id_ff   <= '0;
         held_id_ff     <= '0;
         prev_id_ff     <= '0;
         battery_ff     <= '0;
         humidity_ff    <= '0;
         temperature_ff <= '0;
         button_ff      <= 1'b0;
         error_ff       <= 1'b0;
         last_ok_ff     <= '0;
      end else if (step_valid) begin
         mode_ff        <= mode_in;
         adv_left_ff    <= adv_left_in;
         el_left_ff     <= el_left_in;
         item_kind_ff   <= item_kind_in;
         byte_index_ff  <= byte_index_in;
         low_hold_ff    <= low_hold_in;
         packet_id_ff   <= packet_id_in;
         held_id_ff     <= held_id_in;
         prev_id_ff     <= prev_id_in;
         battery_ff     <= battery_in;
         humidity_ff    <= humidity_in;
         temperature_ff <= temperature_in;
         button_ff      <= button_in;
         error_ff       <= error_in;
         last_ok_ff     <= last_ok_in;
      end
   end

   always_comb begin
      b              = step_item.data_byte;
      mode_in        = mode_ff;
      adv_left_in    = adv_left_ff;
      el_left_in     = el_left_ff;
      item_kind_in   = item_kind_ff;
      byte_index_in  = byte_index_ff;
      low_hold_in    = low_hold_ff;
      packet_id_in   = packet_id_ff;
      held_id_in     = held_id_ff;
      prev_id_in     = prev_id_ff;
      battery_in     = battery_ff;
      humidity_in    = humidity_ff;
      temperature_in = temperature_ff;
      button_in      = button_ff;
      error_in       = error_ff;
      last_ok_in     = last_ok_ff;
      result_valid   = 1'b0;
      item_done      = 1'b0;
      need           = item_size(b);

      // A first byte drops any unfinished advertisement.
      mode_v = step_item.first_byte ? MODE_LEN : mode_ff;
      adv_v  = step_item.first_byte ? step_item.total_length : adv_left_ff;
      el_v   = step_item.first_byte ? 8'd0 : el_left_ff;
      mode_in     = mode_v;
      adv_left_in = adv_v;
      el_left_in  = el_v;

      adv_n      = adv_v - 8'd1;
      in_element = (mode_v != MODE_LEN) && (mode_v != MODE_DRAIN);
      mode_c     = mode_v;
      el         = 8'd0;
      if (in_element) begin
         if (el_v == 8'd0) begin
            mode_c     = MODE_LEN;
            in_element = 1'b0;
         end else begin
            el = el_v - 8'd1;
         end
      end

      if (adv_v != 8'd0) begin
         adv_left_in = adv_n;
         mode_in     = mode_c;
         case (mode_c)
            MODE_LEN: begin
               if (b == 8'd0 || b > adv_n) begin
                  error_in = 1'b1;
                  mode_in  = MODE_DRAIN;
               end else begin
                  el_left_in = b;
                  mode_in    = MODE_TYPE;
               end
            end
            MODE_TYPE: begin
               mode_in = (b == AD_SERVICE_DATA && el >= MIN_SERVICE_LEFT) ?
                         MODE_UUID0 : MODE_SKIP;
            end
            MODE_UUID0: mode_in = (b == UUID_LO) ? MODE_UUID1 : MODE_SKIP;
            MODE_UUID1: mode_in = (b == UUID_HI) ? MODE_FLAGS : MODE_SKIP;
            MODE_FLAGS: begin
               if ((b & (VERSION_MASK | FLAG_ENCRYPTED)) == VERSION_2) begin
                  held_id_in     = packet_id_ff;
                  packet_id_in   = '0;
                  battery_in     = '0;
                  humidity_in    = '0;
                  temperature_in = '0;
                  button_in      = 1'b0;
                  error_in       = 1'b0;
                  mode_in        = MODE_ITEM_TYPE;
               end else begin
                  mode_in = MODE_SKIP;
               end
            end
            MODE_ITEM_TYPE: begin
               if (need == 2'd0) begin
                  error_in = 1'b1;
                  mode_in  = MODE_SKIP;
               end else if ({1'b0, el} + 9'd1 < {7'd0, need}) begin
                  mode_in = MODE_SKIP;
               end else begin
                  item_kind_in  = b;
                  byte_index_in = 2'd0;
                  mode_in       = MODE_ITEM_DATA;
               end
            end
            MODE_ITEM_DATA: begin
               item_done = 1'b1;
               case (item_kind_ff)
                  ITEM_PACKET_ID: begin
                     prev_id_in   = held_id_ff;
                     held_id_in   = b;
                     packet_id_in = b;
                  end
                  ITEM_BATTERY:  battery_in  = b;
                  ITEM_HUMIDITY: humidity_in = b;
                  ITEM_BUTTON:   button_in   = (b == BUTTON_PRESS);
                  ITEM_TEMPERATURE: begin
                     if (byte_index_ff == 2'd0) begin
                        low_hold_in   = b;
                        byte_index_in = 2'd1;
                        item_done     = 1'b0;
                     end else begin
                        temperature_in = {b, low_hold_ff};
                     end
                  end
                  default: item_done = 1'b1;
               endcase
               if (item_done) begin
                  mode_in = MODE_ITEM_TYPE;
                  if (el == 8'd0) begin
                     last_ok_in = step_item.current_time;
                  end
               end
            end
            default: mode_in = mode_c;
         endcase

         if (in_element) begin
            el_left_in = el;
            if (el == 8'd0) begin
               mode_in = MODE_LEN;
            end
         end

         // Final byte: close the advertisement and report.
         if (adv_n == 8'd0) begin
            mode_in      = MODE_LEN;
            el_left_in   = '0;
            result_valid = 1'b1;
         end
      end

      age   = step_item.current_time - last_ok_in;
      fresh = (step_item.current_time < last_ok_in) || (age < max_data_age);

      result.packet_id      = packet_id_in;
      result.battery_level  = battery_in;
      result.humidity       = humidity_in;
      result.temperature    = temperature_in;
      result.button_pressed = button_in;
      result.parse_error    = error_in;
      result.data_valid     = (packet_id_in != prev_id_in) && fresh;
   end

endmodule
`default_nettype wire

>>> rtl/ble_service_data_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BLE service data parser core
// Byte-stream parser for BTHome v2 service data in BLE advertisements.
// ----------------------------------------------------------------------------
// One advertisement byte is taken per cycle while req_stall is low; the
// feedback path from parser state to next parser state sets that rate. A
// transfer on the req side lands in an input register, is parsed by a single
// combinational step against the parser state once the output register is free
// or draining, and on the final byte of an advertisement the decoded values go
// to an output register on the rsp side. Bytes that end no advertisement give
// no transfer on rsp. max_data_age is written through csr_wr_en / csr_wr_data;
// the user must write it only while idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module ble_service_data_parser_core
   import bsdp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_first_byte,
   input  wire logic [7:0]         req_total_length,
   input  wire logic [31:0]        req_current_time,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_packet_id,
   output logic [7:0]              rsp_battery_level,
   output logic [7:0]              rsp_humidity,
   output logic signed [15:0]      rsp_temperature,
   output logic                    rsp_button_pressed,
   output logic                    rsp_parse_error,
   output logic                    rsp_data_valid,
   input  wire logic               csr_wr_en,
   input  wire logic [31:0]        csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   item_type    in_item_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   logic [31:0] max_age_ff;
   logic        advance;
   logic        step_result_valid;
   result_type  step_result;

   // Advance the held byte when the output register is free or draining.
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step_result_valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_age_ff   <= MAX_AGE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            max_age_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_item_ff.data_byte    <= req_data_byte;
         in_item_ff.first_byte   <= req_first_byte;
         in_item_ff.total_length <= req_total_length;
         in_item_ff.current_time <= req_current_time;
      end
      if (advance && step_result_valid) begin
         out_ff <= step_result;
      end
   end

   bsdp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (advance),
      .step_item    (in_item_ff),
      .max_data_age (max_age_ff),
      .result_valid (step_result_valid),
      .result       (step_result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_packet_id      = out_ff.packet_id;
   assign rsp_battery_level  = out_ff.battery_level;
   assign rsp_humidity       = out_ff.humidity;
   assign rsp_temperature    = out_ff.temperature;
   assign rsp_button_pressed = out_ff.button_pressed;
   assign rsp_parse_error    = out_ff.parse_error;
   assign rsp_data_valid     = out_ff.data_valid;

endmodule
`default_nettype wire

>>> bench/ble_service_data_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLE service data parser core testbench
// Streams advertisement bytes into the parser, predicts each end-of-frame
// decode with a cycle-free model of the element walk, and compares every
// rsp transfer against the oldest prediction under random idle and stall.
// ----------------------------------------------------------------------------
module ble_service_data_parser_core_tb;
   import bsdp_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 8;
   localparam int PHASE_BYTES  = 400;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_first_byte = 1'b0;
   logic [7:0]  req_total_length = 8'd0;
   logic [31:0] req_current_time = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_packet_id;
   logic [7:0]  rsp_battery_level;
   logic [7:0]  rsp_humidity;
   logic signed [15:0] rsp_temperature;
   logic        rsp_button_pressed;
   logic        rsp_parse_error;
   logic        rsp_data_valid;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   // byte stream waiting to go out, and decodes waiting to come back
   item_type    pending_bytes[$];
   result_type  expected_decodes[$];

   // frame under construction
   logic [7:0]  frame[$];
   logic [7:0]  elem_body[$];
   logic [31:0] now_s;

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int unsigned fail_count = 0;
   int unsigned decodes_checked = 0;
   int unsigned bytes_queued = 0;
   int unsigned frames_built = 0;
   int unsigned cycle_count = 0;

   // parser state as the block should hold it
   mode_type    walk_mode;
   logic [7:0]  advert_left;
   logic [7:0]  elem_left;
   logic [7:0]  item_code;
   logic [1:0]  item_step;
   logic [7:0]  temp_low;
   logic [7:0]  pid;
   logic [7:0]  held_pid;
   logic [7:0]  prev_pid;
   logic [7:0]  battery;
   logic [7:0]  humidity;
   logic [15:0] temperature;
   logic        button;
   logic        err;
   logic [31:0] stamp;
   logic [31:0] max_age;

   always #5 clock = ~clock;

   ble_service_data_parser_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_total_length   (req_total_length),
      .req_current_time   (req_current_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_packet_id      (rsp_packet_id),
      .rsp_battery_level  (rsp_battery_level),
      .rsp_humidity       (rsp_humidity),
      .rsp_temperature    (rsp_temperature),
      .rsp_button_pressed (rsp_button_pressed),
      .rsp_parse_error    (rsp_parse_error),
      .rsp_data_valid     (rsp_data_valid),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 40)
         $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Advance the parser by one accepted byte; queue a decode on the final byte.
   task automatic predict_byte(input item_type it);
      logic [7:0] b;
      logic [7:0] adv;
      logic [7:0] el;
      logic       in_el;
      logic       done;
      logic       fresh;
      int         need;
      result_type r;
      b  = it.data_byte;
      el = 8'd0;
      if (it.first_byte) begin
         walk_mode   = MODE_LEN;
         advert_left = it.total_length;
         elem_left   = 8'd0;
      end
      if (advert_left == 8'd0)
         return;
      adv         = advert_left - 8'd1;
      advert_left = adv;

      in_el = (walk_mode != MODE_LEN) && (walk_mode != MODE_DRAIN);
      if (in_el) begin
         if (elem_left == 8'd0) begin
            walk_mode = MODE_LEN;
            in_el     = 1'b0;
         end else begin
            el = elem_left - 8'd1;
         end
      end

      case (walk_mode)
         MODE_LEN: begin
            if (b == 8'd0 || b > adv) begin
               err       = 1'b1;
               walk_mode = MODE_DRAIN;
            end else begin
               elem_left = b;
               walk_mode = MODE_TYPE;
            end
         end
         MODE_TYPE:
            walk_mode = (b == AD_SERVICE_DATA && el >= MIN_SERVICE_LEFT) ? MODE_UUID0 : MODE_SKIP;
         MODE_UUID0:
            walk_mode = (b == UUID_LO) ? MODE_UUID1 : MODE_SKIP;
         MODE_UUID1:
            walk_mode = (b == UUID_HI) ? MODE_FLAGS : MODE_SKIP;
         MODE_FLAGS: begin
            if ((b & (VERSION_MASK | FLAG_ENCRYPTED)) == VERSION_2) begin
               held_pid    = pid;
               pid         = 8'd0;
               battery     = 8'd0;
               humidity    = 8'd0;
               temperature = 16'd0;
               button      = 1'b0;
               err         = 1'b0;
               walk_mode   = MODE_ITEM_TYPE;
            end else begin
               walk_mode = MODE_SKIP;
            end
         end
         MODE_ITEM_TYPE: begin
            case (b)
               ITEM_PACKET_ID, ITEM_BATTERY, ITEM_HUMIDITY, ITEM_BUTTON: need = 2;
               ITEM_TEMPERATURE: need = 3;
               default: need = 0;
            endcase
            if (need == 0) begin
               err       = 1'b1;
               walk_mode = MODE_SKIP;
            end else if (int'(el) + 1 < need) begin
               walk_mode = MODE_SKIP;
            end else begin
               item_code = b;
               item_step = 2'd0;
               walk_mode = MODE_ITEM_DATA;
            end
         end
         MODE_ITEM_DATA: begin
            done = 1'b1;
            case (item_code)
               ITEM_PACKET_ID: begin
                  prev_pid = held_pid;
                  held_pid = b;
                  pid      = b;
               end
               ITEM_BATTERY:  battery  = b;
               ITEM_HUMIDITY: humidity = b;
               ITEM_BUTTON:   button   = (b == BUTTON_PRESS);
               ITEM_TEMPERATURE: begin
                  if (item_step == 2'd0) begin
                     temp_low  = b;
                     item_step = 2'd1;
                     done      = 1'b0;
                  end else begin
                     temperature = {b, temp_low};
                  end
               end
               default: ;
            endcase
            if (done) begin
               walk_mode = MODE_ITEM_TYPE;
               // stamp only when the item closes the element
               if (el == 8'd0)
                  stamp = it.current_time;
            end
         end
         default: ;
      endcase

      if (in_el) begin
         elem_left = el;
         if (el == 8'd0)
            walk_mode = MODE_LEN;
      end

      if (adv != 8'd0)
         return;

      walk_mode = MODE_LEN;
      elem_left = 8'd0;
      fresh = (it.current_time < stamp) || ((it.current_time - stamp) < max_age);
      r.packet_id      = pid;
      r.battery_level  = battery;
      r.humidity       = humidity;
      r.temperature    = temperature;
      r.button_pressed = button;
      r.parse_error    = err;
      r.data_valid     = (pid != prev_pid) && fresh;
      expected_decodes.push_back(r);
   endtask

   // Send n_send bytes of the frame, the first flagged with len_field as total.
   // Bytes past the end of the frame are random filler.
   task automatic queue_frame(input int len_field, input int n_send, input bit jitter);
      item_type it;
      for (int i = 0; i < n_send; i++) begin
         it.data_byte    = (i < frame.size()) ? frame[i] : 8'($urandom);
         it.first_byte   = (i == 0);
         it.total_length = (i == 0) ? 8'(len_field) : 8'($urandom);
         it.current_time = (jitter && $urandom_range(0, 7) == 0) ? $urandom : now_s;
         pending_bytes.push_back(it);
      end
      bytes_queued += n_send;
      frames_built++;
      frame.delete();
   endtask

   task automatic send_frame(input bit jitter);
      queue_frame(frame.size(), frame.size(), jitter);
   endtask

   // Bytes with no first-byte flag: ignored when no advertisement is open.
   task automatic push_loose(input int n);
      item_type it;
      for (int i = 0; i < n; i++) begin
         it.data_byte    = 8'($urandom);
         it.first_byte   = 1'b0;
         it.total_length = 8'($urandom);
         it.current_time = ($urandom_range(0, 1) == 0) ? now_s : $urandom;
         pending_bytes.push_back(it);
      end
      bytes_queued += n;
   endtask

   // Close elem_body as one length-type element of the frame.
   task automatic push_element(input logic [7:0] ad_type);
      frame = {frame, 8'(elem_body.size() + 1), ad_type, elem_body};
      elem_body.delete();
   endtask

   task automatic build_service(input int n_items, input logic [7:0] flags,
                                input bit odd_item, input bit cut_short);
      logic [7:0] t;
      elem_body = {UUID_LO, UUID_HI, flags};
      for (int k = 0; k < n_items; k++) begin
         case ($urandom_range(0, 7))
            0, 1: begin
               // small id pool so repeats and changes both show up
               t = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
               elem_body = {elem_body, ITEM_PACKET_ID, t};
            end
            2: elem_body = {elem_body, ITEM_BATTERY, 8'($urandom)};
            3: elem_body = {elem_body, ITEM_HUMIDITY, 8'($urandom)};
            4, 5: elem_body = {elem_body, ITEM_TEMPERATURE, 8'($urandom), 8'($urandom)};
            default: begin
               t = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
               elem_body = {elem_body, ITEM_BUTTON, t};
            end
         endcase
      end
      if (odd_item) begin
         do t = 8'($urandom);
         while (t == ITEM_PACKET_ID || t == ITEM_BATTERY || t == ITEM_HUMIDITY ||
                t == ITEM_TEMPERATURE || t == ITEM_BUTTON);
         elem_body = {elem_body, t, ITEM_BATTERY, 8'($urandom)};
      end
      if (cut_short) begin
         if ($urandom_range(0, 1) == 0)
            elem_body = {elem_body, ITEM_TEMPERATURE, 8'($urandom)};
         else
            elem_body = {elem_body, ITEM_BATTERY};
      end
      push_element(AD_SERVICE_DATA);
   endtask

   task automatic push_filler();
      int n;
      n = $urandom_range(0, 4);
      if ($urandom_range(0, 1) == 0) begin
         elem_body = {8'h06};
         push_element(8'h01);
      end else begin
         for (int i = 0; i < n; i++)
            elem_body.push_back(8'($urandom));
         push_element(8'($urandom));
      end
   endtask

   task automatic gen_frame();
      int         kind;
      int         span;
      int         pos;
      logic [7:0] flags;
      case ($urandom_range(0, 19))
         0: now_s = $urandom;
         1: now_s = now_s + $urandom;
         2: now_s = now_s - $urandom_range(1, 50);
         default: now_s = now_s + $urandom_range(0, 4);
      endcase
      flags = VERSION_2 | (8'($urandom) & 8'h1E);
      if ($urandom_range(0, 15) == 0)
         flags = 8'($urandom);
      kind = $urandom_range(0, 99);

      if (kind < 66) begin
         if ($urandom_range(0, 2) == 0)
            push_filler();
         build_service($urandom_range(0, 6), flags, $urandom_range(0, 11) == 0,
                       $urandom_range(0, 9) == 0);
         if ($urandom_range(0, 3) == 0)
            push_filler();
         send_frame($urandom_range(0, 7) == 0);
      end else if (kind < 72) begin
         if ($urandom_range(0, 3) == 0) begin
            // service element too short to hold a header
            elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_BATTERY};
            push_element(AD_SERVICE_DATA);
         end else begin
            build_service($urandom_range(1, 4), VERSION_2, 1'b0, 1'b0);
            pos = $urandom_range(1, 4);
            frame[pos] = 8'($urandom);
         end
         send_frame(1'b0);
      end else if (kind < 78) begin
         build_service($urandom_range(0, 3), VERSION_2, 1'b0, 1'b0);
         span = $urandom_range(0, 3);
         frame.push_back(($urandom_range(0, 2) == 0) ? 8'd0 : 8'(span + $urandom_range(1, 20)));
         for (int i = 0; i < span; i++)
            frame.push_back(8'($urandom));
         send_frame(1'b0);
      end else if (kind < 85) begin
         // cut off and restart with the next frame
         build_service($urandom_range(0, 5), flags, 1'b0, 1'b0);
         span = frame.size();
         queue_frame(span, $urandom_range(1, span - 1), 1'b0);
      end else if (kind < 90) begin
         push_loose($urandom_range(1, 4));
      end else if (kind < 94) begin
         build_service($urandom_range(0, 4), flags, 1'b0, 1'b0);
         queue_frame(frame.size(), frame.size() + $urandom_range(1, 3), 1'b0);
      end else begin
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
         for (int i = 0; i < span; i++)
            frame.push_back(8'($urandom));
         send_frame(1'b1);
      end
   endtask

   task automatic write_max_age(input logic [31:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      max_age = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Wait until every byte is taken and every decode has come back.
   task automatic settle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_decodes.size() != 0);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // Driver: hold a stalled transfer, otherwise launch the next byte or idle.
   always @(posedge clock) begin
      item_type taken;
      item_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.data_byte    = req_data_byte;
            taken.first_byte   = req_first_byte;
            taken.total_length = req_total_length;
            taken.current_time = req_current_time;
            predict_byte(taken);
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_byte = pending_bytes.pop_front();
               req_valid        <= 1'b1;
               req_data_byte    <= next_byte.data_byte;
               req_first_byte   <= next_byte.first_byte;
               req_total_length <= next_byte.total_length;
               req_current_time <= next_byte.current_time;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each decode transfer against the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_decodes.size() == 0) begin
               report_mismatch("unexpected transfer, packet_id", rsp_packet_id, 32'd0);
            end else begin
               want = expected_decodes.pop_front();
               decodes_checked++;
               if (rsp_packet_id !== want.packet_id)
                  report_mismatch("packet_id", rsp_packet_id, want.packet_id);
               if (rsp_battery_level !== want.battery_level)
                  report_mismatch("battery_level", rsp_battery_level, want.battery_level);
               if (rsp_humidity !== want.humidity)
                  report_mismatch("humidity", rsp_humidity, want.humidity);
               if (rsp_temperature !== want.temperature)
                  report_mismatch("temperature", rsp_temperature, want.temperature);
               if (rsp_button_pressed !== want.button_pressed)
                  report_mismatch("button_pressed", rsp_button_pressed, want.button_pressed);
               if (rsp_parse_error !== want.parse_error)
                  report_mismatch("parse_error", rsp_parse_error, want.parse_error);
               if (rsp_data_valid !== want.data_valid)
                  report_mismatch("data_valid", rsp_data_valid, want.data_valid);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d decodes outstanding",
                  cycle_count, expected_decodes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [31:0] age;
      int unsigned phase_start;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 32'd0;
      walk_mode   = MODE_LEN;
      advert_left = 8'd0;
      elem_left   = 8'd0;
      item_code   = 8'd0;
      item_step   = 2'd0;
      temp_low    = 8'd0;
      pid         = 8'd0;
      held_pid    = 8'd0;
      prev_pid    = 8'd0;
      battery     = 8'd0;
      humidity    = 8'd0;
      temperature = 16'd0;
      button      = 1'b0;
      err         = 1'b0;
      stamp       = 32'd0;
      max_age     = MAX_AGE_RESET;
      now_s       = 32'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero element length in a one-byte frame
      now_s = 32'd0;
      frame = {8'h00};
      send_frame(1'b0);
      // every item type, negative temperature, button pressed
      now_s = 32'd100;
      elem_body = {8'h06};
      push_element(8'h01);
      elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_PACKET_ID, 8'd5, ITEM_BATTERY, 8'd100,
                   ITEM_HUMIDITY, 8'd55, ITEM_TEMPERATURE, 8'h18, 8'hFC, ITEM_BUTTON, 8'h01};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      // same packet id again
      now_s = 32'd101;
      elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_PACKET_ID, 8'd5, ITEM_BUTTON, 8'h02};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      // unknown item type, later element still walked
      elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_PACKET_ID, 8'd6, 8'h7F, ITEM_BATTERY, 8'd9};
      push_element(AD_SERVICE_DATA);
      elem_body = {8'h06};
      push_element(8'h01);
      send_frame(1'b0);
      // temperature item cut short by the element end
      elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_PACKET_ID, 8'd7, ITEM_TEMPERATURE, 8'h33};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      // element length past the end of the frame
      frame = {8'h05, AD_SERVICE_DATA, UUID_LO};
      send_frame(1'b0);
      // encrypted, wrong version, wrong UUID, header too short
      elem_body = {UUID_LO, UUID_HI, VERSION_2 | FLAG_ENCRYPTED, ITEM_PACKET_ID, 8'd8};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      elem_body = {UUID_LO, UUID_HI, 8'h60, ITEM_PACKET_ID, 8'd8};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      elem_body = {UUID_LO, 8'hFD, VERSION_2, ITEM_PACKET_ID, 8'd8};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      elem_body = {UUID_LO, UUID_HI, VERSION_2};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      // new frame before the old one ends
      elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_PACKET_ID, 8'd9};
      push_element(AD_SERVICE_DATA);
      queue_frame(frame.size(), 4, 1'b0);
      elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_PACKET_ID, 8'd10};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      // stray bytes, then an empty frame
      push_loose(3);
      frame = {AD_SERVICE_DATA};
      queue_frame(0, 1, 1'b0);
      push_loose(2);
      // clock behind the stamp
      now_s = 32'd50;
      elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_PACKET_ID, 8'd11};
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      // age just inside and just at the limit
      now_s = 32'd649;
      elem_body = {8'h06};
      push_element(8'h01);
      send_frame(1'b0);
      now_s = 32'd650;
      elem_body = {8'h06};
      push_element(8'h01);
      send_frame(1'b0);
      // longest frame, all-ones bytes and time
      now_s = 32'hFFFF_FFFF;
      elem_body = {UUID_LO, UUID_HI, VERSION_2, ITEM_PACKET_ID, 8'hFF, ITEM_TEMPERATURE,
                   8'hFF, 8'hFF, ITEM_BUTTON, 8'hFF, ITEM_HUMIDITY, 8'hFF};
      while (elem_body.size() < 252)
         elem_body = {elem_body, ITEM_BATTERY, 8'($urandom)};
      elem_body.push_back(ITEM_BATTERY);
      push_element(AD_SERVICE_DATA);
      send_frame(1'b0);
      settle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  age = 32'hFFFF_FFFF; end
            1: begin send_idle_pct = 71; stall_pct = 0;  age = 32'd0; end
            2: begin send_idle_pct = 0;  stall_pct = 71; age = 32'd1; end
            default: begin
               send_idle_pct = 38;
               stall_pct     = 38;
               age           = $urandom_range(2, 40);
            end
         endcase
         write_max_age(age);
         @(negedge clock);
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES)
            gen_frame();
         settle();
      end

      $display("Streamed %0d bytes in %0d frames through four data-age settings",
               bytes_queued, frames_built);
      $display("Checked %0d decodes in %0d cycles, %0d mismatches",
               decodes_checked, cycle_count, fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
